[rtl/wrr_pkg.sv]
// Shared constants, payload structs and helpers for the write-record ring.
// No dependencies; used by wrr_ctrl and write_record_ring_with_offset_lookup.
package wrr_pkg;

  localparam int unsigned RING_DEPTH = 16;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam int unsigned HANDLE_W   = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned OFFSET_W   = 20;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned REC_W      = HANDLE_W + SIZE_W;
  // running byte total over the whole ring, wide enough for the offset too
  localparam int unsigned CMP_W      = (SIZE_W + IDX_W > OFFSET_W) ? SIZE_W + IDX_W : OFFSET_W;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_FIND = 1'b1;

  typedef struct packed {
    logic                func;
    logic [HANDLE_W-1:0] entry_handle;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFFSET_W-1:0] find_offset;
  } wrr_in_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   hit_slot;
    logic [HANDLE_W-1:0] hit_handle;
    logic [SIZE_W-1:0]   byte_in_entry;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
    logic [SIZE_W-1:0]   evicted_size;
  } wrr_out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [REC_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } wrr_ram_req_t;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] r;
    if (idx == IDX_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + IDX_W'(1);
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

[rtl/write_record_ring_with_offset_lookup.sv]
// Top level of the write-record ring: record RAM, sequencer, output register.
// Depends on wrr_pkg, wrr_ram and wrr_ctrl.
// Add: accept, write step, hand-off; the result word lands in the output
//   register at the hand-off, and ready returns once the hand-off is taken.
// Find: one ring slot is checked per cycle through the shared adder/compare,
//   at most RING_DEPTH slots (16), then the result word waits for the hand-off.
// Reset (async, active low) empties the ring: indices to 0, full flag and all
//   per-slot valid bits cleared, so every slot reads as handle 0, size 0.
module write_record_ring_with_offset_lookup (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wrr_pkg::wrr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wrr_pkg::wrr_out_t out_data_o
);

  wrr_pkg::wrr_ram_req_t      ram_req;
  logic [wrr_pkg::REC_W-1:0]  ram_rdata;
  logic                       res_valid;
  logic                       res_ready;
  wrr_pkg::wrr_out_t          res_data;

  logic                       out_valid_q;
  wrr_pkg::wrr_out_t          out_data_q;

  // Record store: {handle, size} per slot. Never-written slots are masked
  // by the valid bits inside the sequencer, so the array needs no clearing.
  wrr_ram #(
    .Width (wrr_pkg::REC_W),
    .Depth (wrr_pkg::RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: add = one write step (eviction read was issued at accept),
  // find = walk from the oldest slot summing sizes until the offset falls in or the ring runs out.
  wrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  // Output register decouples the sink: a new word may be accepted and
  // worked on while the previous result waits here.
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/wrr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wrr_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/wrr_ctrl.sv]
// Sequencer and shared add/compare unit for the write-record ring.
// Depends on wrr_pkg; drives the record RAM through a wrr_ram_req_t.
module wrr_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  wrr_pkg::wrr_in_t         in_data_i,
  output wrr_pkg::wrr_ram_req_t    ram_req_o,
  input  logic [wrr_pkg::REC_W-1:0] ram_rdata_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output wrr_pkg::wrr_out_t        res_data_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADD  = 4'b0010,
    S_FIND = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  wrr_pkg::wrr_in_t                item_q;
  logic [wrr_pkg::IDX_W-1:0]       wr_idx_q, wr_idx_d;
  logic [wrr_pkg::IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic                            ring_full_q, ring_full_d;
  logic [wrr_pkg::RING_DEPTH-1:0]  valid_q, valid_d;
  logic                            rd_vld_q;
  logic [wrr_pkg::IDX_W-1:0]       slot_q, slot_d;
  logic [wrr_pkg::IDX_W-1:0]       cnt_q, cnt_d;
  logic [wrr_pkg::CMP_W-1:0]       total_q, total_d;
  wrr_pkg::wrr_out_t               res_q, res_d;

  logic                            accept;
  logic [wrr_pkg::HANDLE_W-1:0]    rec_handle;
  logic [wrr_pkg::SIZE_W-1:0]      rec_size;
  logic [wrr_pkg::CMP_W-1:0]       sum;
  logic [wrr_pkg::CMP_W-1:0]       off_ext;
  logic [wrr_pkg::CMP_W-1:0]       diff;
  logic                            hit;
  logic [wrr_pkg::IDX_W-1:0]       wr_next;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // record read last cycle; slots never written read as empty
  assign rec_handle = rd_vld_q ? ram_rdata_i[wrr_pkg::REC_W-1:wrr_pkg::SIZE_W] : '0;
  assign rec_size   = rd_vld_q ? ram_rdata_i[wrr_pkg::SIZE_W-1:0] : '0;

  // shared unit: one add, one compare and one subtract per visited slot
  assign off_ext = wrr_pkg::CMP_W'(item_q.find_offset);
  assign sum     = total_q + wrr_pkg::CMP_W'(rec_size);
  assign hit     = off_ext < sum;
  assign diff    = off_ext - total_q;
  assign wr_next = wrr_pkg::next_slot(wr_idx_q);

  always_comb begin
    ram_req_o.we    = (state_q == S_ADD);
    ram_req_o.waddr = wr_idx_q;
    ram_req_o.wdata = {item_q.entry_handle, item_q.entry_size};
    // walk reads one slot ahead; otherwise keep the oldest slot on the bus
    ram_req_o.raddr = (state_q == S_FIND) ? wrr_pkg::next_slot(slot_q) : rd_idx_q;
  end

  always_comb begin
    state_d     = state_q;
    wr_idx_d    = wr_idx_q;
    rd_idx_d    = rd_idx_q;
    ring_full_d = ring_full_q;
    valid_d     = valid_q;
    slot_d      = slot_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    res_d       = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          slot_d  = rd_idx_q;
          cnt_d   = '0;
          total_d = '0;
          state_d = (in_data_i.func == wrr_pkg::FUNC_FIND) ? S_FIND : S_ADD;
        end
      end
      S_ADD: begin
        res_d = '0;
        if (ring_full_q) begin
          res_d.evicted        = 1'b1;
          res_d.evicted_handle = rec_handle;
          res_d.evicted_size   = rec_size;
          rd_idx_d             = wrr_pkg::next_slot(rd_idx_q);
        end else begin
          ring_full_d = (wr_next == rd_idx_q);
        end
        valid_d[wr_idx_q] = 1'b1;
        wr_idx_d          = wr_next;
        state_d           = S_RESP;
      end
      S_FIND: begin
        if (hit) begin
          res_d               = '0;
          res_d.found         = 1'b1;
          res_d.hit_slot      = wrr_pkg::slot_field(slot_q);
          res_d.hit_handle    = rec_handle;
          res_d.byte_in_entry = diff[wrr_pkg::SIZE_W-1:0];
          state_d             = S_RESP;
        end else if (cnt_q == wrr_pkg::IDX_W'(wrr_pkg::RING_DEPTH - 1)) begin
          res_d   = '0;
          state_d = S_RESP;
        end else begin
          total_d = sum;
          slot_d  = wrr_pkg::next_slot(slot_q);
          cnt_d   = cnt_q + wrr_pkg::IDX_W'(1);
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      ring_full_q <= 1'b0;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      ring_full_q <= ring_full_d;
      valid_q     <= valid_d;
      rd_vld_q    <= valid_q[ram_req_o.raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    slot_q  <= slot_d;
    cnt_q   <= cnt_d;
    total_q <= total_d;
    res_q   <= res_d;
  end

  assign res_valid_o = (state_q == S_RESP);
  assign res_data_o  = res_q;

  a_full_idx_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_full_q |-> (wr_idx_q == rd_idx_q))
    else $error("ring full with write and read index apart");

  a_full_all_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_full_q |-> (&valid_q))
    else $error("ring full but a slot was never written");

  a_add_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_data_i.func == wrr_pkg::FUNC_ADD)) |=> (state_q == S_ADD))
    else $error("accepted add did not enter the add step");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND && cnt_q == wrr_pkg::IDX_W'(wrr_pkg::RING_DEPTH - 1))
      |=> (state_q == S_RESP))
    else $error("find walk ran past the last slot");

endmodule
